// ----- hdl/mst_pkg.sv -----
`default_nettype none
package mst_pkg;

   typedef enum logic [2:0] {
      CMD_START   = 3'd0,
      CMD_RESTART = 3'd1,
      CMD_STOP    = 3'd2,
      CMD_SETLOOP = 3'd3,
      CMD_QUERY   = 3'd4,
      CMD_TICK    = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [2:0]  slot;
      logic [2:0]  prior_slot;
      logic        prior_valid;
      logic [31:0] duration;
      logic        loop_on;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [2:0] result_slot;
      logic       expired;
      logic       running;
      logic       looping;
      logic       last;
   } rsp_type;

endpackage
`default_nettype wire

// ----- hdl/mst_if.sv -----
`default_nettype none
interface mst_req_if;
   import mst_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mst_rsp_if;
   import mst_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/multiplexed_software_timers_unit.sv -----
// channel | dir | payload
// req     | in  | command, slot, prior_slot, prior_valid, duration, loop_on
// rsp     | out | status, result_slot, expired, running, looping, last
// One item at a time. A non-tick beat passes S_RD and S_EXEC and is then
// registered as valid. A tick passes S_RD and then a scan pass (a read and a
// compare per slot, in S_SCAN and S_SWAIT); per expiry S_SERV issues the beat
// before it and S_OUT services it, then one more pass follows. Reset is
// synchronous and clears the marks; a slot's match and reload are never used
// while it is stopped. A stalled rsp beat holds the sequencer and the input.
`default_nettype none
module multiplexed_software_timers_unit
   import mst_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input wire logic clock,
   input wire logic reset,
   mst_req_if.sink  req,
   mst_rsp_if.source rsp
);
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RD   = 7'b0000010,
      S_EXEC = 7'b0000100,
      S_SCAN = 7'b0001000,
      S_SWAIT= 7'b0010000,
      S_SERV = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   // memories: one read per cycle, registered
   logic [31:0] match_mem [SLOTS];
   logic [31:0] reload_mem [SLOTS];
   logic [31:0] match_rd_ff, reload_rd_ff;
   logic [SW-1:0] rd_addr;
   logic          wr_en;
   logic [SW-1:0] wr_addr;
   logic [31:0]   wr_match, wr_reload;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         match_mem[wr_addr]  <= wr_match;
         reload_mem[wr_addr] <= wr_reload;
      end
      match_rd_ff  <= match_mem[rd_addr];
      reload_rd_ff <= reload_mem[rd_addr];
   end

   state_type      state_ff, state_in;
   req_type        req_ff;
   logic [SLOTS-1:0] run_ff, run_in, loop_ff, loop_in, done_ff, done_in;
   logic [31:0]    tick_ff, tick_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [SW-1:0]  best_ff, best_in, scan_slot_ff, scan_slot_in;
   logic           found_ff, found_in, any_ff, any_in;
   logic [31:0]    best_m_ff, best_m_in;
   rsp_type        out_ff, out_in;
   logic           out_v_ff, out_v_in, cont_ff, cont_in;
   logic [SW-1:0]  free_slot;
   logic           free_found;
   logic           s_ok, p_ok;
   logic [SW-1:0]  s_idx, p_idx;

   // lowest free slot
   always_comb begin
      free_slot  = '0;
      free_found = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!run_ff[i]) begin
            free_slot  = SW'(i);
            free_found = 1'b1;
         end
      end
   end

   assign s_ok  = 32'(req_ff.slot) < SLOTS;
   assign p_ok  = 32'(req_ff.prior_slot) < SLOTS;
   assign s_idx = SW'(req_ff.slot);
   assign p_idx = SW'(req_ff.prior_slot);

   assign req.ready = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;

   always_comb begin
      state_in  = state_ff;
      run_in    = run_ff;
      loop_in   = loop_ff;
      done_in   = done_ff;
      tick_in   = tick_ff;
      idx_in    = idx_ff;
      best_in   = best_ff;
      found_in  = found_ff;
      best_m_in = best_m_ff;
      any_in    = any_ff;
      scan_slot_in = scan_slot_ff;
      out_in    = out_ff;
      out_v_in  = out_v_ff;
      cont_in   = cont_ff;
      rd_addr   = s_idx;
      wr_en     = 1'b0;
      wr_addr   = s_idx;
      wr_match  = '0;
      wr_reload = '0;
      if (out_v_ff && rsp.ready) out_v_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) state_in = S_RD;
         end
         S_RD: begin
            // read the addressed slot's reload
            rd_addr = s_idx;
            if (req_ff.command == CMD_TICK) begin
               tick_in = tick_ff + 32'd1;
               done_in = '0;
               any_in  = 1'b0;
               idx_in  = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            out_in = '0;
            out_in.last = 1'b1;
            out_in.result_slot = req_ff.slot;
            out_in.status = 1'b1;
            unique case (req_ff.command)
               CMD_START: begin
                  out_in.result_slot = '0;
                  if (free_found) begin
                     out_in.status = 1'b0;
                     out_in.result_slot = 3'(free_slot);
                     out_in.running = 1'b1;
                     if (req_ff.prior_valid && p_ok && run_ff[p_idx]) begin
                        run_in[p_idx]  = 1'b0;
                        loop_in[p_idx] = 1'b0;
                     end
                     run_in[free_slot]  = 1'b1;
                     loop_in[free_slot] = 1'b0;
                     wr_en     = 1'b1;
                     wr_addr   = free_slot;
                     wr_match  = tick_ff + req_ff.duration;
                     wr_reload = req_ff.duration;
                  end
               end
               CMD_RESTART, CMD_STOP, CMD_SETLOOP: begin
                  if (s_ok && run_ff[s_idx]) begin
                     out_in.status = 1'b0;
                     if (req_ff.command == CMD_RESTART) begin
                        wr_en = 1'b1;
                        wr_match  = tick_ff + reload_rd_ff;
                        wr_reload = reload_rd_ff;
                     end else if (req_ff.command == CMD_STOP) begin
                        wr_en = 1'b1;
                        run_in[s_idx]  = 1'b0;
                        loop_in[s_idx] = 1'b0;
                     end else begin
                        loop_in[s_idx] = req_ff.loop_on;
                     end
                  end
                  out_in.running = s_ok && run_in[s_idx];
                  out_in.looping = s_ok && loop_in[s_idx];
               end
               CMD_QUERY: begin
                  out_in.status  = !s_ok;
                  out_in.running = s_ok && run_ff[s_idx];
                  out_in.looping = s_ok && loop_ff[s_idx];
               end
               default: ;
            endcase
            out_v_in = 1'b1;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            // issue read of slot idx
            rd_addr = SW'(idx_ff);
            scan_slot_in = SW'(idx_ff);
            state_in = S_SWAIT;
         end
         S_SWAIT: begin
            // compare this slot against the best so far
            rd_addr = scan_slot_ff;
            if (run_ff[scan_slot_ff] && !done_ff[scan_slot_ff]
                && match_rd_ff <= tick_ff
                && (!found_ff || match_rd_ff < best_m_ff)) begin
               found_in  = 1'b1;
               best_in   = scan_slot_ff;
               best_m_in = match_rd_ff;
            end
            if (idx_ff == CW'(SLOTS - 1)) begin
               state_in = S_SERV;
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = S_SCAN;
            end
         end
         S_SERV: begin
            // wait for the held beat, issue the staged one, then service the best slot
            rd_addr = best_ff;
            if (!out_v_ff || rsp.ready) begin
               if (any_ff && cont_ff) begin
                  // the staged beat is final when nothing else expires
                  out_in.last = !found_ff;
                  out_v_in = 1'b1;
                  cont_in  = 1'b0;
                  if (!found_ff) state_in = S_IDLE;
               end else if (!found_ff) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            rd_addr = best_ff;
            if (!found_ff) begin
               state_in = S_IDLE;
            end else begin
               done_in[best_ff] = 1'b1;
               wr_en   = 1'b1;
               wr_addr = best_ff;
               out_in  = '0;
               out_in.expired = 1'b1;
               out_in.result_slot = 3'(best_ff);
               if (loop_ff[best_ff]) begin
                  wr_match  = tick_ff + reload_rd_ff;
                  wr_reload = reload_rd_ff;
                  out_in.running = 1'b1;
                  out_in.looping = 1'b1;
               end else begin
                  run_in[best_ff]  = 1'b0;
                  loop_in[best_ff] = 1'b0;
               end
               any_in  = 1'b1;
               cont_in = 1'b1;
               found_in = 1'b0;
               idx_in = '0;
               state_in = S_SCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // the staged beat: a tick result is held in out_ff with valid low until
   // the next one (or the end) is known, so that last can be set
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         run_ff   <= '0;
         loop_ff  <= '0;
         tick_ff  <= '0;
         out_v_ff <= 1'b0;
         cont_ff  <= 1'b0;
         any_ff   <= 1'b0;
         found_ff <= 1'b0;
         done_ff  <= '0;
      end else begin
         state_ff <= state_in;
         run_ff   <= run_in;
         loop_ff  <= loop_in;
         tick_ff  <= tick_in;
         out_v_ff <= out_v_in;
         cont_ff  <= cont_in;
         any_ff   <= any_in;
         found_ff <= found_in;
         done_ff  <= done_in;
      end
      if (req.valid && req.ready) req_ff <= req.data;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_m_ff    <= best_m_in;
      scan_slot_ff <= scan_slot_in;
      out_ff       <= out_in;
   end

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("accept while busy");
   a_hold_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("beat dropped");
   a_tick_adv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD && req_ff.command == CMD_TICK) |=> tick_ff == $past(tick_ff) + 32'd1)
      else $error("tick count");
`endif
endmodule
`default_nettype wire

// ----- tb/mst_checker.sv -----
module mst_checker
   import mst_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire req_type req_data,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire rsp_type rsp_data,
   output int errors,
   output int pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOTS = 8;

   // predicted timer state
   logic [31:0] now_ticks;
   logic [31:0] match_at [NSLOTS];
   logic [31:0] reload_of [NSLOTS];
   logic [NSLOTS-1:0] armed;
   logic [NSLOTS-1:0] looped;

   rsp_type timer_events [$];

   function automatic rsp_type make_rsp(logic st, logic [2:0] s, logic ex, logic rn,
                                        logic lp, logic ls);
      rsp_type r;
      r.status = st;
      r.result_slot = s;
      r.expired = ex;
      r.running = rn;
      r.looping = lp;
      r.last = ls;
      return r;
   endfunction

   task automatic release_slot(int s);
      match_at[s] = '0;
      reload_of[s] = '0;
      armed[s] = 1'b0;
      looped[s] = 1'b0;
   endtask

   // advance the timer state by one request beat and queue its responses
   task automatic apply_request(req_type q);
      int free_idx;
      int best;
      int first_new;
      logic [NSLOTS-1:0] serviced;
      logic st;
      free_idx = -1;
      serviced = '0;
      case (q.command)
         CMD_START: begin
            for (int i = NSLOTS - 1; i >= 0; i--)
               if (!armed[i]) free_idx = i;
            if (free_idx < 0) begin
               timer_events.push_back(make_rsp(1'b1, 3'd0, 1'b0, 1'b0, 1'b0, 1'b1));
            end else begin
               if (q.prior_valid && armed[q.prior_slot]) release_slot(int'(q.prior_slot));
               match_at[free_idx] = now_ticks + q.duration;
               reload_of[free_idx] = q.duration;
               looped[free_idx] = 1'b0;
               armed[free_idx] = 1'b1;
               timer_events.push_back(make_rsp(1'b0, free_idx[2:0], 1'b0, 1'b1, 1'b0,
                                               1'b1));
            end
         end
         CMD_RESTART, CMD_STOP, CMD_SETLOOP, CMD_QUERY: begin
            st = 1'b1;
            if (q.command == CMD_QUERY) begin
               st = 1'b0;
            end else if (armed[q.slot]) begin
               st = 1'b0;
               if (q.command == CMD_RESTART)
                  match_at[q.slot] = now_ticks + reload_of[q.slot];
               else if (q.command == CMD_STOP)
                  release_slot(int'(q.slot));
               else
                  looped[q.slot] = q.loop_on;
            end
            timer_events.push_back(make_rsp(st, q.slot, 1'b0, armed[q.slot],
                                            looped[q.slot], 1'b1));
         end
         CMD_TICK: begin
            now_ticks = now_ticks + 32'd1;
            first_new = timer_events.size();
            forever begin
               best = -1;
               for (int i = 0; i < NSLOTS; i++)
                  if (armed[i] && !serviced[i] && match_at[i] <= now_ticks &&
                      (best < 0 || match_at[i] < match_at[best]))
                     best = i;
               if (best < 0) break;
               serviced[best] = 1'b1;
               if (looped[best]) match_at[best] = now_ticks + reload_of[best];
               else release_slot(best);
               timer_events.push_back(make_rsp(1'b0, best[2:0], 1'b1, armed[best],
                                               looped[best], 1'b0));
            end
            if (timer_events.size() > first_new)
               timer_events[timer_events.size() - 1].last = 1'b1;
         end
         default: begin
            timer_events.push_back(make_rsp(1'b1, q.slot, 1'b0, 1'b0, 1'b0, 1'b1));
         end
      endcase
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         now_ticks = '0;
         armed = '0;
         looped = '0;
         for (int i = 0; i < NSLOTS; i++) begin
            match_at[i] = '0;
            reload_of[i] = '0;
         end
         timer_events.delete();
         errors = 0;
      end else begin
         // compare the response beat, then predict the new request beat
         if (rsp_valid && rsp_ready) begin
            if (timer_events.size() == 0) begin
               $error("unexpected response beat: slot %0d", rsp_data.result_slot);
               errors++;
            end else begin
               want = timer_events.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("result_slot", 32'(want.result_slot),
                           32'(rsp_data.result_slot));
               check_field("expired", 32'(want.expired), 32'(rsp_data.expired));
               check_field("running", 32'(want.running), 32'(rsp_data.running));
               check_field("looping", 32'(want.looping), 32'(rsp_data.looping));
               check_field("last", 32'(want.last), 32'(rsp_data.last));
            end
         end
         if (req_valid && req_ready) apply_request(req_data);
      end
      pending = timer_events.size();
   end
endmodule

// ----- tb/tb_multiplexed_software_timers_unit.sv -----
module tb_multiplexed_software_timers_unit;
   import mst_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int errors;
   int pending;
   bit calm = 1'b0;
   bit hold_rsp = 1'b0;

   mst_req_if req ();
   mst_rsp_if rsp ();

   multiplexed_software_timers_unit #(.SLOTS(8)) u_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   mst_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .req_data(req.data),
      .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready),
      .rsp_data(rsp.data),
      .errors(errors),
      .pending(pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.data = '0;
   end

   // present one request beat at the falling edge and hold it until accepted;
   // valid stays high so that a following beat can follow with no gap in valid
   task automatic send_beat(logic [2:0] cmd, logic [2:0] s, logic [2:0] ps, logic pv,
                            logic [31:0] dur, logic lp);
      req_type q;
      q.command = cmd;
      q.slot = s;
      q.prior_slot = ps;
      q.prior_valid = pv;
      q.duration = dur;
      q.loop_on = lp;
      while (!calm && $urandom_range(99) < 37) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.data <= q;
      while (!req.ready) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic random_beat();
      int pick;
      logic [31:0] dur;
      pick = $urandom_range(99);
      dur = ($urandom_range(9) == 0) ? $urandom : $urandom_range(6);
      if (pick < 28)
         send_beat(CMD_START, 3'($urandom), 3'($urandom), 1'($urandom), dur,
                   1'($urandom));
      else if (pick < 62)
         send_beat(CMD_TICK, 3'($urandom), 3'($urandom), 1'($urandom), $urandom,
                   1'($urandom));
      else if (pick < 70)
         send_beat(CMD_RESTART, 3'($urandom), 3'($urandom), 1'($urandom), $urandom,
                   1'($urandom));
      else if (pick < 78)
         send_beat(CMD_STOP, 3'($urandom), 3'($urandom), 1'($urandom), $urandom,
                   1'($urandom));
      else if (pick < 90)
         send_beat(CMD_SETLOOP, 3'($urandom), 3'($urandom), 1'($urandom), $urandom,
                   1'($urandom));
      else if (pick < 97)
         send_beat(CMD_QUERY, 3'($urandom), 3'($urandom), 1'($urandom), $urandom,
                   1'($urandom));
      else
         send_beat(3'($urandom_range(7, 6)), 3'($urandom), 3'($urandom), 1'($urandom),
                   $urandom, 1'($urandom));
   endtask

   // response side: random stalls, one long hold-off, one calm stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: fill the pool, overflow, prior stop, loops, errors, ticks
      for (int i = 0; i < 8; i++) send_beat(CMD_START, 3'd7, 3'd0, 1'b0, 32'(i + 1), 1'b0);
      send_beat(CMD_START, 3'd0, 3'd3, 1'b1, 32'd5, 1'b1);
      send_beat(CMD_SETLOOP, 3'd0, 3'd0, 1'b0, 32'd0, 1'b1);
      send_beat(CMD_SETLOOP, 3'd7, 3'd0, 1'b0, 32'd0, 1'b1);
      send_beat(CMD_STOP, 3'd3, 3'd0, 1'b0, 32'd0, 1'b0);
      send_beat(CMD_START, 3'd0, 3'd2, 1'b1, 32'hFFFF_FFFF, 1'b0);
      send_beat(CMD_START, 3'd0, 3'd5, 1'b1, 32'd0, 1'b0);
      send_beat(CMD_QUERY, 3'd3, 3'd0, 1'b0, 32'd0, 1'b0);
      send_beat(CMD_RESTART, 3'd1, 3'd0, 1'b0, 32'd0, 1'b0);
      send_beat(CMD_STOP, 3'd6, 3'd0, 1'b0, 32'd0, 1'b0);
      send_beat(CMD_RESTART, 3'd6, 3'd0, 1'b0, 32'd0, 1'b0);
      send_beat(3'd6, 3'd4, 3'd0, 1'b0, 32'd0, 1'b0);
      send_beat(3'd7, 3'd2, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1);
      for (int i = 0; i < 6; i++) send_beat(CMD_TICK, 3'd0, 3'd0, 1'b0, 32'd0, 1'b0);
      send_beat(CMD_SETLOOP, 3'd7, 3'd0, 1'b0, 32'd0, 1'b1);

      // hold off responses while requests keep coming
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 12; i++) send_beat(CMD_TICK, 3'd0, 3'd0, 1'b0, 32'd0, 1'b0);
      join

      for (int n = 0; n < 300; n++) begin
         calm = (n >= 120 && n < 170);
         random_beat();
      end
      calm = 1'b0;
      req.valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ----- files.f -----
hdl/mst_pkg.sv
hdl/mst_if.sv
hdl/multiplexed_software_timers_unit.sv
tb/mst_checker.sv
tb/tb_multiplexed_software_timers_unit.sv
